[hdl/char_lcd_nibble_sequencer_defines.svh]
// Assertion macros used by the character LCD nibble sequencer controller.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCDNS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCDNS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lcdns_pkg.sv]
// Package: types, constants and init table of the character LCD nibble sequencer.
`timescale 1ns / 1ps
package lcdns_pkg;

	// request modes
	localparam logic [1:0] MODE_INIT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_WRITE  = 2'd2;
	localparam logic [1:0] MODE_CURSOR = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_COLUMN = 2'd0;
	localparam logic [1:0] CFG_ROW_OFFSET = 2'd1;
	localparam logic [1:0] CFG_SETTLE     = 2'd2;

	// reset values of the registers
	localparam logic [5:0] MAX_COLUMN_RST = 6'd15;
	localparam logic [6:0] ROW_OFFSET_RST = 7'd64;
	localparam logic [9:0] SETTLE_RST     = 10'd100;

	// display commands
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_SET_DDR = 8'h80;

	// delays in microseconds
	localparam logic [15:0] INIT_LEAD_US = 16'd50000;
	localparam logic [12:0] WAKE_GAP_US  = 13'd5000;
	localparam logic [12:0] CMD_GAP_US   = 13'd2000;

	// transfer counts
	localparam int unsigned INIT_STEPS = 12;
	localparam int unsigned STEP_W     = 4;
	localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(INIT_STEPS - 1);
	localparam logic [STEP_W-1:0] BYTE_LAST_STEP = STEP_W'(1);

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  capture;
		logic  load;
		step_t step;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_init;
	} dp_status_t;

	// init sequence: wake-up nibbles 3,3,3,2 then 0x28, 0x0C, 0x06, 0x01
	function automatic logic [3:0] init_nibble(input step_t step);
		logic [3:0] n;
		case (step)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3, 4'd4:       n = 4'h2;
			4'd5:             n = 4'h8;
			4'd7:             n = 4'hC;
			4'd9:             n = 4'h6;
			4'd11:            n = 4'h1;
			default:          n = 4'h0;
		endcase
		return n;
	endfunction

	// extra delay after each init transfer
	function automatic logic [12:0] init_extra(input step_t step);
		logic [12:0] e;
		case (step)
			4'd0, 4'd1, 4'd2, 4'd3:  e = WAKE_GAP_US;
			4'd5, 4'd7, 4'd9, 4'd11: e = CMD_GAP_US;
			default:                 e = 13'd0;
		endcase
		return e;
	endfunction

endpackage

[hdl/lcdns_ctrl.sv]
// Controller: request handshake, transfer step counter and output valid.
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_defines.svh"
module lcdns_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_last,
	output lcdns_pkg::ctrl_cmd_t   cmd,
	input  lcdns_pkg::dp_status_t  status
);

	lcdns_pkg::state_t state_q, state_d;
	lcdns_pkg::step_t  step_q;
	lcdns_pkg::step_t  last_step;
	logic              out_valid_q;
	logic              load;
	logic              at_last;

	assign last_step = status.is_init ? lcdns_pkg::INIT_LAST_STEP : lcdns_pkg::BYTE_LAST_STEP;
	assign at_last   = (step_q == last_step);
	assign load      = (state_q == lcdns_pkg::ST_RUN) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcdns_pkg::ST_IDLE: begin
				if (in_valid) state_d = lcdns_pkg::ST_RUN;
			end
			lcdns_pkg::ST_RUN: begin
				if (load && at_last) state_d = lcdns_pkg::ST_IDLE;
			end
			default: state_d = lcdns_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.load    = 1'b0;
		unique case (state_q)
			lcdns_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			lcdns_pkg::ST_RUN: begin
				cmd.load = load;
			end
			default: ;
		endcase
	end
	assign cmd.step  = step_q;
	assign out_valid = out_valid_q;

	// state, step counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcdns_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) step_q <= at_last ? '0 : step_q + 1'b1;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// last flag rides along with the loaded word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_last <= 1'b0;
		else if (load) out_last <= at_last;
	end

	`LCDNS_ASSERT_NOW(a_step_range, state_q == lcdns_pkg::ST_RUN, step_q <= last_step, "step past end")
	`LCDNS_ASSERT_NOW(a_idle_step0, state_q == lcdns_pkg::ST_IDLE, step_q == '0, "step not cleared")
	`LCDNS_ASSERT_NEXT(a_last_idle, load && at_last, state_q == lcdns_pkg::ST_IDLE, "no return to idle")
	`LCDNS_ASSERT_NEXT(a_cap_run, in_valid && in_ready, state_q == lcdns_pkg::ST_RUN, "no run after accept")

endmodule

[hdl/lcdns_dp.sv]
// Datapath: config registers, request byte forming and output word register.
`timescale 1ns / 1ps
module lcdns_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [9:0]             cfg_data,
	input  logic [1:0]             mode,
	input  logic [7:0]             character,
	input  logic [1:0]             row,
	input  logic [5:0]             column,
	input  lcdns_pkg::ctrl_cmd_t   cmd,
	output lcdns_pkg::dp_status_t  status,
	output logic                   register_select,
	output logic [3:0]             nibble,
	output logic [15:0]            wait_before_us,
	output logic [12:0]            wait_after_us
);

	logic [5:0] max_col_q;
	logic [6:0] row_off_q;
	logic [9:0] settle_q;

	logic       is_init_q;
	logic       rs_q;
	logic       gap_q;
	logic [7:0] byte_q;

	logic [5:0]  col_c;
	logic [6:0]  addr;
	logic [7:0]  byte_d;
	logic        rs_d;
	logic        gap_d;
	logic [3:0]  nib_d;
	logic [12:0] extra_d;
	logic [15:0] before_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_col_q <= lcdns_pkg::MAX_COLUMN_RST;
			row_off_q <= lcdns_pkg::ROW_OFFSET_RST;
			settle_q  <= lcdns_pkg::SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcdns_pkg::CFG_MAX_COLUMN: max_col_q <= cfg_data[5:0];
				lcdns_pkg::CFG_ROW_OFFSET: row_off_q <= cfg_data[6:0];
				lcdns_pkg::CFG_SETTLE:     settle_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// cursor address: clamp row and column, wrap to 7 bits
	assign col_c = (column > max_col_q) ? max_col_q : column;
	assign addr  = ((row != 2'd0) ? row_off_q : 7'd0) + {1'b0, col_c};

	// byte, register select and command gap per mode
	always_comb begin
		byte_d = lcdns_pkg::CMD_CLEAR;
		rs_d   = 1'b0;
		gap_d  = 1'b0;
		unique case (mode)
			lcdns_pkg::MODE_INIT:  ;
			lcdns_pkg::MODE_CLEAR: gap_d = 1'b1;
			lcdns_pkg::MODE_WRITE: begin
				byte_d = character;
				rs_d   = 1'b1;
			end
			lcdns_pkg::MODE_CURSOR: byte_d = lcdns_pkg::CMD_SET_DDR | {1'b0, addr};
			default: ;
		endcase
	end

	// request registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_init_q <= 1'b0;
		end else if (cmd.capture) begin
			is_init_q <= (mode == lcdns_pkg::MODE_INIT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= byte_d;
			rs_q   <= rs_d;
			gap_q  <= gap_d;
		end
	end

	assign status.is_init = is_init_q;

	// transfer word for the current step
	always_comb begin
		if (is_init_q) begin
			nib_d    = lcdns_pkg::init_nibble(cmd.step);
			extra_d  = lcdns_pkg::init_extra(cmd.step);
			before_d = (cmd.step == '0) ? lcdns_pkg::INIT_LEAD_US : 16'd0;
		end else begin
			nib_d    = cmd.step[0] ? byte_q[3:0] : byte_q[7:4];
			extra_d  = (cmd.step[0] && gap_q) ? lcdns_pkg::CMD_GAP_US : 13'd0;
			before_d = 16'd0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			register_select <= is_init_q ? 1'b0 : rs_q;
			nibble          <= nib_d;
			wait_before_us  <= before_d;
			wait_after_us   <= {3'd0, settle_q} + extra_d;
		end
	end

endmodule

[hdl/char_lcd_nibble_sequencer.sv]
// Top level of the character LCD nibble sequencer.
`timescale 1ns / 1ps
// Turns one display request (init, clear, write character, set cursor) into the
// 4-bit bus transfers a character LCD needs, one output word per transfer with
// register select, nibble, wait before and after the strobe, and a last flag.
// Init gives twelve words, every other mode two. A request is taken while
// idle, then one word is loaded into the single output register per cycle
// while the consumer keeps up; the next request is accepted once the final
// word is loaded, even while that word still waits to be taken. Config writes
// take effect at once and belong only to idle periods.
module char_lcd_nibble_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  character,
	input  logic [1:0]  row,
	input  logic [5:0]  column,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        register_select,
	output logic [3:0]  nibble,
	output logic [15:0] wait_before_us,
	output logic [12:0] wait_after_us,
	output logic        last
);

	lcdns_pkg::ctrl_cmd_t  cmd;
	lcdns_pkg::dp_status_t status;

	lcdns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_last  (last),
		.cmd       (cmd),
		.status    (status)
	);

	lcdns_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (mode),
		.character       (character),
		.row             (row),
		.column          (column),
		.cmd             (cmd),
		.status          (status),
		.register_select (register_select),
		.nibble          (nibble),
		.wait_before_us  (wait_before_us),
		.wait_after_us   (wait_after_us)
	);

endmodule

[dv/lcd_transfer_checker.sv]
// Checker for the character LCD nibble sequencer: predicts every bus transfer and compares.
`timescale 1ns / 1ps
module lcd_transfer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  character,
	input  logic [1:0]  row,
	input  logic [5:0]  column,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        register_select,
	input  logic [3:0]  nibble,
	input  logic [15:0] wait_before_us,
	input  logic [12:0] wait_after_us,
	input  logic        last,
	output int          mismatches,
	output int          outstanding
);

	// init command bytes and wake-up nibbles
	localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
	localparam logic [7:0] DISPLAY_ON    = 8'h0C;
	localparam logic [7:0] ENTRY_INC     = 8'h06;
	localparam logic [3:0] WAKE_NIB      = 4'h3;
	localparam logic [3:0] BUS4_NIB      = 4'h2;
	localparam logic       RS_CMD        = 1'b0;
	localparam logic       RS_DATA       = 1'b1;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nib;
		logic [15:0] lead;
		logic [12:0] after;
		logic        fin;
	} xfer_t;

	xfer_t expected_q[$];

	// shadow copy of the configuration registers
	logic [5:0] col_limit = lcdns_pkg::MAX_COLUMN_RST;
	logic [6:0] row1_base = lcdns_pkg::ROW_OFFSET_RST;
	logic [9:0] settle_us = lcdns_pkg::SETTLE_RST;
	int         fail_n = 0;

	task automatic queue_nibble(input logic rs, input logic [3:0] nib,
			input logic [15:0] lead, input logic [12:0] extra, input logic fin);
		xfer_t x;
		x.rs = rs;
		x.nib = nib;
		x.lead = lead;
		x.after = {3'b000, settle_us} + extra;
		x.fin = fin;
		expected_q.push_back(x);
	endtask

	// high nibble first; only the low nibble carries the extra delay
	task automatic queue_byte(input logic rs, input logic [7:0] b,
			input logic [12:0] extra, input logic fin);
		queue_nibble(rs, b[7:4], 16'd0, 13'd0, 1'b0);
		queue_nibble(rs, b[3:0], 16'd0, extra, fin);
	endtask

	task automatic predict_request(input logic [1:0] md, input logic [7:0] ch,
			input logic [1:0] r, input logic [5:0] c);
		logic [5:0] c_eff;
		logic [6:0] addr;
		case (md)
			lcdns_pkg::MODE_INIT: begin
				queue_nibble(RS_CMD, WAKE_NIB, lcdns_pkg::INIT_LEAD_US,
					lcdns_pkg::WAKE_GAP_US, 1'b0);
				queue_nibble(RS_CMD, WAKE_NIB, 16'd0, lcdns_pkg::WAKE_GAP_US, 1'b0);
				queue_nibble(RS_CMD, WAKE_NIB, 16'd0, lcdns_pkg::WAKE_GAP_US, 1'b0);
				queue_nibble(RS_CMD, BUS4_NIB, 16'd0, lcdns_pkg::WAKE_GAP_US, 1'b0);
				queue_byte(RS_CMD, FUNC_SET_4BIT, lcdns_pkg::CMD_GAP_US, 1'b0);
				queue_byte(RS_CMD, DISPLAY_ON, lcdns_pkg::CMD_GAP_US, 1'b0);
				queue_byte(RS_CMD, ENTRY_INC, lcdns_pkg::CMD_GAP_US, 1'b0);
				queue_byte(RS_CMD, lcdns_pkg::CMD_CLEAR, lcdns_pkg::CMD_GAP_US, 1'b1);
			end
			lcdns_pkg::MODE_CLEAR: begin
				queue_byte(RS_CMD, lcdns_pkg::CMD_CLEAR, lcdns_pkg::CMD_GAP_US, 1'b1);
			end
			lcdns_pkg::MODE_WRITE: begin
				queue_byte(RS_DATA, ch, 13'd0, 1'b1);
			end
			default: begin
				// rows above one fold onto row one, column clamps, address wraps
				c_eff = (c > col_limit) ? col_limit : c;
				addr = ((r != 2'd0) ? row1_base : 7'd0) + {1'b0, c_eff};
				queue_byte(RS_CMD, lcdns_pkg::CMD_SET_DDR | {1'b0, addr}, 13'd0, 1'b1);
			end
		endcase
	endtask

	// watch config writes, requests and transfers
	always @(posedge clk or negedge arst_n) begin : watch
		xfer_t want;
		if (!arst_n) begin
			col_limit = lcdns_pkg::MAX_COLUMN_RST;
			row1_base = lcdns_pkg::ROW_OFFSET_RST;
			settle_us = lcdns_pkg::SETTLE_RST;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lcdns_pkg::CFG_MAX_COLUMN: col_limit = cfg_data[5:0];
					lcdns_pkg::CFG_ROW_OFFSET: row1_base = cfg_data[6:0];
					lcdns_pkg::CFG_SETTLE:     settle_us = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_request(mode, character, row, column);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fail_n++;
					if (fail_n <= 10)
						$display("%0t: transfer word with none expected: rs=%0d nib=%h", $realtime,
							register_select, nibble);
				end else begin
					want = expected_q.pop_front();
					if (want.rs !== register_select || want.nib !== nibble ||
							want.lead !== wait_before_us || want.after !== wait_after_us ||
							want.fin !== last) begin
						fail_n++;
						if (fail_n <= 10)
							$display({"%0t: transfer mismatch: expected rs=%0d nib=%h before=%0d ",
								"after=%0d last=%0d, got rs=%0d nib=%h before=%0d after=%0d last=%0d"},
								$realtime, want.rs, want.nib, want.lead, want.after, want.fin,
								register_select, nibble, wait_before_us, wait_after_us, last);
					end
				end
			end
		end
		mismatches <= fail_n;
		outstanding <= expected_q.size();
	end

endmodule

[dv/tb.sv]
// Testbench top for the character LCD nibble sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

	// the HOLD_CYCLES receiver hold is the longest quiet stretch of a correct run
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_GAP     = 4;
	localparam int HOLD_CYCLES    = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [7:0]  character;
	logic [1:0]  row;
	logic [5:0]  column;
	logic        out_valid;
	logic        out_ready;
	logic        register_select;
	logic [3:0]  nibble;
	logic [15:0] wait_before_us;
	logic [12:0] wait_after_us;
	logic        last;
	int          mismatches;
	int          outstanding;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	char_lcd_nibble_sequencer DUT (.*);

	lcd_transfer_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, or a counted hold
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left = hold_left - 1;
			end else
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send_request(input logic [1:0] md, input logic [7:0] ch,
			input logic [1:0] r, input logic [5:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		character <= ch;
		row <= r;
		column <= c;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic random_request();
		send_request(2'($urandom_range(3)), 8'($urandom_range(255)),
			2'($urandom_range(3)), 6'($urandom_range(63)));
	endtask

	// stop offering and wait for every expected transfer
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	// write all three registers; block must be idle
	task automatic load_config(input logic [9:0] max_col, input logic [9:0] row_off,
			input logic [9:0] settle);
		cfg_we <= 1'b1;
		cfg_index <= lcdns_pkg::CFG_MAX_COLUMN;
		cfg_data <= max_col;
		@(posedge clk);
		cfg_index <= lcdns_pkg::CFG_ROW_OFFSET;
		cfg_data <= row_off;
		@(posedge clk);
		cfg_index <= lcdns_pkg::CFG_SETTLE;
		cfg_data <= settle;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		load_config(10'($urandom_range(1023)), 10'($urandom_range(1023)),
			10'($urandom_range(1023)));
		repeat (n) random_request();
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= lcdns_pkg::CFG_MAX_COLUMN;
		cfg_data <= 10'd0;
		in_valid <= 1'b0;
		mode <= lcdns_pkg::MODE_INIT;
		character <= 8'd0;
		row <= 2'd0;
		column <= 6'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset configuration
		send_request(lcdns_pkg::MODE_INIT, 8'h00, 2'd0, 6'd0);
		send_request(lcdns_pkg::MODE_CLEAR, 8'hFF, 2'd3, 6'd63);
		send_request(lcdns_pkg::MODE_WRITE, 8'h00, 2'd0, 6'd0);
		send_request(lcdns_pkg::MODE_WRITE, 8'hFF, 2'd0, 6'd0);
		send_request(lcdns_pkg::MODE_WRITE, 8'hA5, 2'd3, 6'd63);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd0, 6'd0);
		send_request(lcdns_pkg::MODE_CURSOR, 8'hFF, 2'd1, 6'd15);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd2, 6'd20);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd0, 6'd63);
		send_request(lcdns_pkg::MODE_INIT, 8'hFF, 2'd3, 6'd63);
		drain_results();

		// widest column, top offset: address wraps
		load_config(10'h3FF, 10'h3FF, 10'd1000);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd1, 6'd63);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd3, 6'd40);
		send_request(lcdns_pkg::MODE_INIT, 8'h00, 2'd0, 6'd0);
		send_request(lcdns_pkg::MODE_WRITE, 8'h81, 2'd0, 6'd0);
		drain_results();

		// all zero: no settle wait, every column clamps to zero
		load_config(10'd0, 10'd0, 10'd0);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd1, 6'd50);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd0, 6'd1);
		send_request(lcdns_pkg::MODE_INIT, 8'h00, 2'd0, 6'd0);
		send_request(lcdns_pkg::MODE_CLEAR, 8'h00, 2'd0, 6'd0);
		drain_results();

		// settle above 1000, upper data bits dropped by the narrow registers
		load_config(10'h2AA, 10'h155, 10'd1023);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd1, 6'd63);
		send_request(lcdns_pkg::MODE_CURSOR, 8'h00, 2'd2, 6'd42);
		send_request(lcdns_pkg::MODE_INIT, 8'h00, 2'd0, 6'd0);
		send_request(lcdns_pkg::MODE_WRITE, 8'h3C, 2'd0, 6'd0);
		drain_results();

		// no idling, with a long receiver hold that backs up the input
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_config(10'($urandom_range(1023)), 10'($urandom_range(1023)),
			10'($urandom_range(1023)));
		repeat (10) random_request();
		hold_left = HOLD_CYCLES;
		repeat (12) random_request();
		drain_results();
		repeat (8) random_request();
		drain_results();

		run_phase(65, 0, 24);
		run_phase(0, 65, 24);
		run_phase(35, 35, 24);

		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[char_lcd_nibble_sequencer.f]
+incdir+hdl
hdl/lcdns_pkg.sv
hdl/lcdns_ctrl.sv
hdl/lcdns_dp.sv
hdl/char_lcd_nibble_sequencer.sv
dv/lcd_transfer_checker.sv
dv/tb.sv
